>>> design/mmbce_pkg.sv
package mmbce_pkg;

  // Mode codes held in the crc_mode register.
  localparam logic [1:0] MODE_CRC8  = 2'd0;
  localparam logic [1:0] MODE_CRC16 = 2'd1;
  localparam logic [1:0] MODE_CRC32 = 2'd2;
  localparam logic [1:0] MODE_CCITT = 2'd3;

  // Register indexes on the configuration port (byte address divided by four).
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_SEED = 1'b1;

  localparam logic [7:0]  POLY8_REFL   = 8'h8C;
  localparam logic [15:0] POLY16_PAR   = 16'hC001;
  localparam logic [31:0] POLY32_REFL  = 32'hEDB88320;
  localparam logic [15:0] POLY16_CCITT = 16'h1021;

  typedef logic [31:0] crc_word_t;

  // 1-Wire CRC8, reflected, one bit per step.
  function automatic logic [7:0] fold8(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ POLY8_REFL) : (c >> 1);
    end
    return c;
  endfunction

  // Reflected CRC16 with 0xA001, in its byte-wide parity form.
  function automatic logic [15:0] fold16(input logic [15:0] crc, input logic [7:0] data);
    logic [7:0]  d;
    logic [15:0] c;
    d = data ^ crc[7:0];
    c = {8'd0, crc[15:8]};
    if (^d) begin
      c = c ^ POLY16_PAR;
    end
    c = c ^ ({8'd0, d} << 6) ^ ({8'd0, d} << 7);
    return c;
  endfunction

  // Reflected CRC32; the register holds the inverted CRC.
  function automatic logic [31:0] fold32(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ POLY32_REFL) : (c >> 1);
    end
    return c;
  endfunction

  // CCITT shift form, MSB first: data bits enter at the low end.
  function automatic logic [15:0] fold_ccitt(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] s;
    logic [7:0]  d;
    logic        top;
    s = crc;
    d = data;
    for (int i = 0; i < 8; i++) begin
      top = s[15];
      s = {s[14:0], d[7]};
      if (top) begin
        s = s ^ POLY16_CCITT;
      end
      d = {d[6:0], 1'b0};
    end
    return s;
  endfunction

endpackage

>>> design/multi_mode_byte_crc_engine_top.sv
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  one message byte, start flag in tuser
// m_*       out        m_tvalid/m_tready  CRC after that byte, 32 bits
// APB       in/out     psel/penable       crc_mode at 0x0, seed_value at 0x4
//
// Each byte is captured in an input register and then folded into the running
// CRC by one byte-wide XOR network whose result lands in the output register, so
// a byte may be transferred every cycle while the output is not stalled.
// The one-byte feedback through the CRC register sets that rate.
// Reset (synchronous, active high) clears both valid flags, the CRC register and
// the configuration registers.
// While the output is stalled one further byte is held in the input register; the
// input side then stops taking transfers until the output register drains.
module multi_mode_byte_crc_engine_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  input  logic                 s_tuser,   // [0] start_of_message
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output mmbce_pkg::crc_word_t m_tdata,   // [31:0] crc_value
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mmbce_pkg::*;

  logic [1:0]  crc_mode;
  logic [31:0] seed_value;
  crc_word_t   crc_register;
  crc_word_t   crc_register_next;
  crc_word_t   crc_start;
  crc_word_t   crc_value_next;

  // Input register stage.
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;

  logic        advance;

  // Configuration port: always ready, registers selected by word address.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEED) ? seed_value : {30'd0, crc_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode   <= MODE_CRC8;
      seed_value <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_MODE) begin
        crc_mode <= pwdata[1:0];
      end else begin
        seed_value <= pwdata;
      end
    end
  end

  // The held byte moves on when the output register is empty or being emptied.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  // Starting value: the seed truncated to the mode width, inverted for CRC32.
  always_comb begin
    if (in_start) begin
      case (crc_mode)
        MODE_CRC8:  crc_start = {24'd0, seed_value[7:0]};
        MODE_CRC32: crc_start = ~seed_value;
        default:    crc_start = {16'd0, seed_value[15:0]};
      endcase
    end else begin
      crc_start = crc_register;
    end
  end

  // One byte folded per mode; bits above the mode width come out cleared.
  always_comb begin
    case (crc_mode)
      MODE_CRC8: begin
        crc_register_next = {24'd0, fold8(crc_start[7:0], in_byte)};
        crc_value_next    = crc_register_next;
      end
      MODE_CRC16: begin
        crc_register_next = {16'd0, fold16(crc_start[15:0], in_byte)};
        crc_value_next    = crc_register_next;
      end
      MODE_CRC32: begin
        crc_register_next = fold32(crc_start, in_byte);
        crc_value_next    = ~crc_register_next;
      end
      default: begin
        crc_register_next = {16'd0, fold_ccitt(crc_start[15:0], in_byte)};
        crc_value_next    = crc_register_next;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (advance) begin
        crc_register <= crc_register_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= crc_value_next;
    end
  end

  // A byte that cannot move on stays held in the input register.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("held input byte lost");

  // Narrow modes leave the upper half of the CRC register clear.
  a_narrow_upper: assert property (@(posedge clk) disable iff (rst)
    advance && crc_mode != MODE_CRC32 |=> crc_register[31:16] == 16'd0)
    else $error("upper CRC bits set in a 16-bit or 8-bit mode");

  // CRC32 results are the complement of the stored register.
  a_crc32_out: assert property (@(posedge clk) disable iff (rst)
    advance && crc_mode == MODE_CRC32 |=> m_tdata == ~crc_register)
    else $error("CRC32 result does not match inverted register");

  // CRC8 results fit in one byte.
  a_crc8_out: assert property (@(posedge clk) disable iff (rst)
    advance && crc_mode == MODE_CRC8 |=> m_tdata[31:8] == 24'd0)
    else $error("CRC8 result wider than eight bits");

  // Nothing is offered on the output right after reset.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
